// File: sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants for the first-fit block allocator: defaults, command
// codes, status codes and field widths of the stream payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int MAX_CELLS_DEF = 128;
    localparam int MAX_IDS_DEF   = 256;

    localparam int CMD_W    = 2;
    localparam int SIZE_W   = 8;
    localparam int BID_W    = 8;
    localparam int STAT_W   = 2;
    localparam int NEWID_W  = 8;
    localparam int POOL_W   = 8;
    localparam int LEN_W    = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEFRAG = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_ILLEGAL = 2'd2;

    localparam logic [POOL_W-1:0] POOL_RST = 8'd128;

endpackage

`default_nettype wire

// File: sv/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit cell allocator with erase and order-keeping compaction.
//
// Commands arrive on the s_axis channel, one transaction per command. An
// allocate always returns one m_axis transaction (status and new id); an
// erase returns one only for an illegal id; defragment returns none.
// One command is worked at a time; s_axis_tready is high while the block
// is idle. Allocate scans the cells one at a time through the single read
// port of the cell owner RAM, then writes each allocated cell. Erase reads
// the block's start and length, then clears each freed cell. Defragment
// packs the stored cells in a pass over all cells, then clears each cell
// above the packed area.
// After reset the owner RAM is swept to zero, during which no command is
// accepted. The user must write the pool size register through i_cfg_wen
// and i_cfg_wdata only while the block is idle; the block does not enforce it.
// A result waits in an output register while the receiver stalls; the
// block does not finish a following command that needs that register.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_core #(
    parameter int MAX_CELLS = ffba_pkg::MAX_CELLS_DEF,
    parameter int MAX_IDS   = ffba_pkg::MAX_IDS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_wen,
    input  wire [ffba_pkg::POOL_W-1:0]     i_cfg_wdata,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // command [1:0], size [9:2], block_id [17:10], zero fill above
    input  wire [ffba_pkg::S_DATA_W-1:0]   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // status [1:0], new_id [9:2], zero fill above
    output logic [ffba_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    localparam int CW   = $clog2(MAX_CELLS);
    localparam int CNTW = $clog2(MAX_CELLS + 1);
    localparam int IW   = $clog2(MAX_IDS);
    localparam int LW   = ffba_pkg::LEN_W;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A_RD  = 4'd2;
    localparam logic [3:0] S_A_EV  = 4'd3;
    localparam logic [3:0] S_A_FL  = 4'd4;
    localparam logic [3:0] S_E_RD  = 4'd5;
    localparam logic [3:0] S_E_EV  = 4'd6;
    localparam logic [3:0] S_E_CL  = 4'd7;
    localparam logic [3:0] S_D_RD  = 4'd8;
    localparam logic [3:0] S_D_EV  = 4'd9;
    localparam logic [3:0] S_D_CL  = 4'd10;
    localparam logic [3:0] S_RES   = 4'd11;

    logic [3:0]                    r_state, n_state;
    logic [CNTW-1:0]               r_i, n_i;
    logic [CNTW-1:0]               r_run, n_run;
    logic [CNTW-1:0]               r_k, n_k;
    logic [LW-1:0]                 r_cnt, n_cnt;
    logic [CNTW-1:0]               r_nx, n_nx;
    logic [IW-1:0]                 r_prev, n_prev;
    logic [ffba_pkg::SIZE_W-1:0]   r_size, n_size;
    logic [ffba_pkg::BID_W-1:0]    r_bid, n_bid;
    logic [IW-1:0]                 r_last, n_last;
    logic [ffba_pkg::POOL_W-1:0]   r_pool;
    logic                          r_ovalid, n_ovalid;
    logic [ffba_pkg::STAT_W-1:0]   r_ostat, n_ostat;
    logic [ffba_pkg::NEWID_W-1:0]  r_oid, n_oid;
    logic [ffba_pkg::STAT_W-1:0]   r_pstat, n_pstat;
    logic [ffba_pkg::NEWID_W-1:0]  r_pid, n_pid;

    logic            c_we;
    logic [CW-1:0]   c_waddr;
    logic [IW-1:0]   c_wdata;
    logic [IW-1:0]   c_rdata;
    logic            s_we;
    logic [IW-1:0]   s_waddr;
    logic [CW-1:0]   s_wdata;
    logic [CW-1:0]   s_rdata;
    logic            l_we;
    logic [IW-1:0]   l_waddr;
    logic [LW-1:0]   l_wdata;
    logic [LW-1:0]   l_rdata;
    logic [IW-1:0]   meta_raddr;

    logic [CNTW-1:0]               cells;
    logic [IW-1:0]                 alloc_id;
    logic [ffba_pkg::CMD_W-1:0]    in_cmd;
    logic [ffba_pkg::SIZE_W-1:0]   in_size;
    logic [ffba_pkg::BID_W-1:0]    in_bid;
    logic                          in_acc;
    logic                          out_free;

    assign in_cmd  = s_axis_tdata[1:0];
    assign in_size = s_axis_tdata[9:2];
    assign in_bid  = s_axis_tdata[17:10];

    assign cells = (32'(r_pool) > MAX_CELLS) ? CNTW'(MAX_CELLS) : CNTW'(r_pool);
    assign alloc_id   = r_last + IW'(1);
    assign meta_raddr = IW'(r_bid);
    assign out_free   = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_oid, r_ostat};

    ffba_ram #(.WIDTH(IW), .DEPTH(MAX_CELLS)) u_owner (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (r_i[CW-1:0]),
        .o_rdata (c_rdata)
    );

    ffba_ram #(.WIDTH(CW), .DEPTH(MAX_IDS)) u_start (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (s_rdata)
    );

    ffba_ram #(.WIDTH(LW), .DEPTH(MAX_IDS)) u_len (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (l_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_run    = r_run;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_nx     = r_nx;
        n_prev   = r_prev;
        n_size   = r_size;
        n_bid    = r_bid;
        n_last   = r_last;
        n_pstat  = r_pstat;
        n_pid    = r_pid;
        n_ovalid = r_ovalid;
        n_ostat  = r_ostat;
        n_oid    = r_oid;
        c_we     = 1'b0;
        c_waddr  = r_k[CW-1:0];
        c_wdata  = '0;
        s_we     = 1'b0;
        s_waddr  = alloc_id;
        s_wdata  = '0;
        l_we     = 1'b0;
        l_waddr  = alloc_id;
        l_wdata  = '0;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                c_we    = 1'b1;
                c_waddr = r_i[CW-1:0];
                if (32'(r_i) == MAX_CELLS - 1) begin
                    n_i     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_i = r_i + CNTW'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_size = in_size;
                    n_bid  = in_bid;
                    n_i    = '0;
                    n_run  = '0;
                    n_nx   = '0;
                    n_prev = '0;
                    case (in_cmd)
                        ffba_pkg::CMD_ALLOC: begin
                            if (in_size == '0 || 32'(r_last) >= MAX_IDS - 1) begin
                                n_pstat = ffba_pkg::ST_NOSPACE;
                                n_pid   = '0;
                                n_state = S_RES;
                            end else begin
                                n_state = S_A_RD;
                            end
                        end
                        ffba_pkg::CMD_ERASE: begin
                            if (in_bid == '0 || 32'(in_bid) > 32'(r_last)) begin
                                n_pstat = ffba_pkg::ST_ILLEGAL;
                                n_pid   = '0;
                                n_state = S_RES;
                            end else begin
                                n_state = S_E_RD;
                            end
                        end
                        ffba_pkg::CMD_DEFRAG: begin
                            n_state = S_D_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_A_RD: begin
                if (r_i >= cells) begin
                    n_pstat = ffba_pkg::ST_NOSPACE;
                    n_pid   = '0;
                    n_state = S_RES;
                end else begin
                    n_state = S_A_EV;
                end
            end
            S_A_EV: begin
                n_state = S_A_RD;
                n_i     = r_i + CNTW'(1);
                if (c_rdata == '0) begin
                    n_run = r_run + CNTW'(1);
                    if (32'(r_run) + 1 >= 32'(r_size)) begin
                        n_k     = CNTW'(32'(r_i) + 1 - 32'(r_size));
                        n_cnt   = r_size;
                        s_we    = 1'b1;
                        s_wdata = CW'(32'(r_i) + 1 - 32'(r_size));
                        l_we    = 1'b1;
                        l_wdata = r_size;
                        n_state = S_A_FL;
                    end
                end else begin
                    n_run = '0;
                end
            end
            S_A_FL: begin
                c_we    = 1'b1;
                c_wdata = alloc_id;
                n_k     = r_k + CNTW'(1);
                n_cnt   = r_cnt - LW'(1);
                if (r_cnt == LW'(1)) begin
                    n_last  = alloc_id;
                    n_pstat = ffba_pkg::ST_OK;
                    n_pid   = 8'(alloc_id);
                    n_state = S_RES;
                end
            end
            S_E_RD: begin
                n_state = S_E_EV;
            end
            S_E_EV: begin
                if (l_rdata == '0) begin
                    n_pstat = ffba_pkg::ST_ILLEGAL;
                    n_pid   = '0;
                    n_state = S_RES;
                end else begin
                    n_k     = CNTW'(s_rdata);
                    n_cnt   = l_rdata;
                    l_we    = 1'b1;
                    l_waddr = meta_raddr;
                    n_state = S_E_CL;
                end
            end
            S_E_CL: begin
                c_we  = (32'(r_k) < MAX_CELLS);
                n_k   = r_k + CNTW'(1);
                n_cnt = r_cnt - LW'(1);
                if (r_cnt == LW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_D_RD: begin
                n_state = S_D_EV;
            end
            S_D_EV: begin
                if (c_rdata != '0) begin
                    c_we    = 1'b1;
                    c_waddr = r_nx[CW-1:0];
                    c_wdata = c_rdata;
                    n_nx    = r_nx + CNTW'(1);
                    if (c_rdata != r_prev) begin
                        s_we    = 1'b1;
                        s_waddr = c_rdata;
                        s_wdata = r_nx[CW-1:0];
                    end
                end
                n_prev = c_rdata;
                if (32'(r_i) == MAX_CELLS - 1) begin
                    n_state = S_D_CL;
                end else begin
                    n_i     = r_i + CNTW'(1);
                    n_state = S_D_RD;
                end
            end
            S_D_CL: begin
                if (32'(r_nx) == MAX_CELLS) begin
                    n_i     = '0;
                    n_state = S_IDLE;
                end else begin
                    c_we    = 1'b1;
                    c_waddr = r_nx[CW-1:0];
                    n_nx    = r_nx + CNTW'(1);
                end
            end
            S_RES: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_pstat;
                    n_oid    = r_pid;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_i      <= '0;
            r_last   <= '0;
            r_pool   <= ffba_pkg::POOL_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
            if (i_cfg_wen) begin
                r_pool <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_run   <= n_run;
        r_k     <= n_k;
        r_cnt   <= n_cnt;
        r_nx    <= n_nx;
        r_prev  <= n_prev;
        r_size  <= n_size;
        r_bid   <= n_bid;
        r_pstat <= n_pstat;
        r_pid   <= n_pid;
        r_ostat <= n_ostat;
        r_oid   <= n_oid;
    end

    a_last_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_INIT |=> r_last >= $past(r_last))
        else $error("identifier counter went backwards");

    a_last_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_last) <= MAX_IDS - 1)
        else $error("identifier counter beyond range");

    a_fail_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ffba_pkg::ST_OK |-> m_axis_tdata[9:2] == '0)
        else $error("failed transaction carries an identifier");

    a_ok_fresh_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RES && n_state == S_IDLE && r_pstat == ffba_pkg::ST_OK
        |=> 8'(r_last) == m_axis_tdata[9:2])
        else $error("allocated identifier differs from counter");

endmodule

`default_nettype wire

// File: sv/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
